>>> rtl/core/srsw_pkg.sv
// Shared types and codes for the selective-repeat sender window.
package srsw_pkg;

    // Field widths of the command and response beats.
    localparam int SEQ_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    // Command kinds.
    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Timer actions reported with each response.
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    // Response status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_BAD_CSUM = 2'd2;
    localparam logic [1:0] STAT_OUT_WIN  = 2'd3;

    // One command beat.
    typedef struct packed {
        logic [1:0]              kind;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [SEQ_BITS-1:0]     seq_num;
        logic                    ack_ok;
    } srsw_cmd_t;

    // One response beat.
    typedef struct packed {
        logic                    tx_valid;
        logic [SEQ_BITS-1:0]     tx_seq;
        logic [PAYLOAD_BITS-1:0] tx_payload;
        logic [1:0]              timer_action;
        logic [SEQ_BITS-1:0]     timer_seq;
        logic [1:0]              status;
        logic                    window_full;
        logic [SEQ_BITS-1:0]     window_base;
    } srsw_rsp_t;

endpackage

>>> rtl/core/srsw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/selective_repeat_sender_window.sv
// A send, a rejected command or kind 3 gives its response in the cycle after start.
// A timeout in the window goes through ST_READ for the payload RAM read, then responds.
// A good ack goes through ST_SLIDE, which retires one acknowledged leading slot per cycle, then responds.
// Throughput: a new command can be taken at the edge that ends the previous response beat,
// so immediate commands run one per cycle; done is a one-cycle strobe and cannot be stalled.
// Reset clears the window, counters and acked flags at once; the payload store is not cleared.
module selective_repeat_sender_window #(
    parameter int WINDOW = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  srsw_pkg::srsw_cmd_t cmd,
    output logic               done,
    output srsw_pkg::srsw_rsp_t rsp
);

    import srsw_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_SLIDE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [SEQ_BITS-1:0]     last_seq_reg, last_seq_next;
    logic [SEQ_BITS-1:0]     base_seq_reg, base_seq_next;
    logic [CNT_W-1:0]        outstanding_reg, outstanding_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [WINDOW-1:0]       acked_reg, acked_next;
    logic [SEQ_BITS-1:0]     seq_reg, seq_next;
    logic                    done_reg, done_next;
    srsw_rsp_t               rsp_reg, rsp_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        send_slot;
    logic [IDX_W-1:0]        hit_slot;
    logic [PAYLOAD_BITS-1:0] ram_rdata;
    logic [SEQ_BITS-1:0]     win_off;
    logic                    in_win;
    logic [IDX_W-1:0]        head_inc;

    // Map a logical window offset to its physical slot in the circular store.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W+1)'(WINDOW))
        begin
            sum = sum - (IDX_W+1)'(WINDOW);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Window position of the acked or timed-out sequence number.
    assign win_off   = cmd.seq_num - base_seq_reg - SEQ_BITS'(1);
    assign in_win    = win_off < SEQ_BITS'(outstanding_reg);
    assign hit_slot  = slot_of(head_reg, win_off[IDX_W-1:0]);
    assign send_slot = slot_of(head_reg, outstanding_reg[IDX_W-1:0]);
    assign head_inc  = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + IDX_W'(1);

    // Payload store, one entry per window slot.
    srsw_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (send_slot),
        .wdata (cmd.payload),
        .raddr (hit_slot),
        .rdata (ram_rdata)
    );

    // Command sequencer: decode, payload read, window slide and response build.
    always_comb
    begin
        state_next       = state_reg;
        last_seq_next    = last_seq_reg;
        base_seq_next    = base_seq_reg;
        outstanding_next = outstanding_reg;
        head_next        = head_reg;
        acked_next       = acked_reg;
        seq_next         = seq_reg;
        done_next        = 1'b0;
        rsp_next         = '0;
        ram_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.kind)
                        KIND_SEND:
                        begin
                            done_next = 1'b1;
                            if (outstanding_reg >= CNT_W'(WINDOW))
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we                  = 1'b1;
                                last_seq_next           = last_seq_reg + SEQ_BITS'(1);
                                outstanding_next        = outstanding_reg + CNT_W'(1);
                                acked_next[send_slot]   = 1'b0;
                                rsp_next.tx_valid       = 1'b1;
                                rsp_next.tx_seq         = last_seq_next;
                                rsp_next.tx_payload     = cmd.payload;
                                rsp_next.timer_action   = TMR_START;
                                rsp_next.timer_seq      = last_seq_next;
                            end
                        end
                        KIND_ACK:
                        begin
                            if (!cmd.ack_ok)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_BAD_CSUM;
                            end
                            else if (!in_win)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_OUT_WIN;
                            end
                            else
                            begin
                                acked_next[hit_slot] = 1'b1;
                                seq_next             = cmd.seq_num;
                                state_next           = ST_SLIDE;
                            end
                        end
                        KIND_TIMEOUT:
                        begin
                            if (!in_win)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_OUT_WIN;
                            end
                            else
                            begin
                                seq_next   = cmd.seq_num;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Payload of the timed-out slot is on the RAM output now.
                done_next             = 1'b1;
                rsp_next.tx_valid     = 1'b1;
                rsp_next.tx_seq       = seq_reg;
                rsp_next.tx_payload   = ram_rdata;
                rsp_next.timer_action = TMR_RESTART;
                rsp_next.timer_seq    = seq_reg;
                state_next            = ST_IDLE;
            end
            ST_SLIDE:
            begin
                // Retire one leading acknowledged slot per cycle.
                if ((outstanding_reg != '0) && acked_reg[head_reg])
                begin
                    acked_next[head_reg] = 1'b0;
                    head_next            = head_inc;
                    base_seq_next        = base_seq_reg + SEQ_BITS'(1);
                    outstanding_next     = outstanding_reg - CNT_W'(1);
                end
                else
                begin
                    done_next             = 1'b1;
                    rsp_next.timer_action = TMR_STOP;
                    rsp_next.timer_seq    = seq_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Window status after this step.
        rsp_next.window_full = outstanding_next >= CNT_W'(WINDOW);
        rsp_next.window_base = base_seq_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_seq_reg    <= '0;
            base_seq_reg    <= '0;
            outstanding_reg <= '0;
            head_reg        <= '0;
            acked_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_seq_reg    <= last_seq_next;
            base_seq_reg    <= base_seq_next;
            outstanding_reg <= outstanding_next;
            head_reg        <= head_next;
            acked_reg       <= acked_next;
            done_reg        <= done_next;
        end
    end

    // Response beat and saved sequence number.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        seq_reg <= seq_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // The window never holds more than its capacity.
    a_outstanding_max: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CNT_W'(WINDOW))
        else $error("outstanding count exceeds window size");

    // The newest sequence number leads the base by exactly the outstanding count.
    a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
        (last_seq_reg - base_seq_reg) == SEQ_BITS'(outstanding_reg))
        else $error("sequence span does not match outstanding count");

    // The base only moves during a slide, and by one.
    a_base_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (base_seq_reg != $past(base_seq_reg)) |->
            ($past(state_reg) == ST_SLIDE) &&
            (base_seq_reg == $past(base_seq_reg) + SEQ_BITS'(1)))
        else $error("window base moved outside a slide");

    // A transmitted packet always comes with a timer start or restart.
    a_tx_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.tx_valid) |->
            ((rsp.timer_action == TMR_START) || (rsp.timer_action == TMR_RESTART)))
        else $error("transmit without timer action");

    // A rejected send only happens with a full window.
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == STAT_FULL)) |-> rsp.window_full)
        else $error("send rejected while window not full");
`endif

endmodule
